FILE: hw/rtl/rfs_pkg.sv
// Shared types and constants for the range filter swing signal block.
// Used by rfs_mul, rfs_alpha and range_filter_swing_signal; depends on nothing.
package rfs_pkg;

  localparam int PRICE_W  = 32;
  localparam int PERIOD_W = 11;
  localparam int MULT_W   = 7;
  localparam int ALPHA_W  = 17;
  localparam int AVG_W    = 48;
  localparam int AVG_FRAC = 16;
  localparam int RANGE_W  = 40;
  localparam int MUL_A_W  = 17;
  localparam int MUL_B_W  = 24;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 65;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT   = 2'd1;

  // Reset register values and the alphas that follow from them
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 11'd14;
  localparam logic [MULT_W-1:0]   MULT_RST       = 7'd3;
  localparam logic [ALPHA_W-1:0]  ALPHA_FAST_RST = 17'd8738;
  localparam logic [ALPHA_W-1:0]  ALPHA_SLOW_RST = 17'd4681;

  // Alpha divider: dividend is 2.0 in Q2.16 plus half the divisor
  localparam int DIV_DVD_W = 18;
  localparam int DIV_DIV_W = 12;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_DVD_W-1:0] ALPHA_TWO = 18'd131072;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 5'd17;

  // Trend direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Remembered condition codes
  localparam logic [1:0] COND_NONE  = 2'd0;
  localparam logic [1:0] COND_LONG  = 2'd1;
  localparam logic [1:0] COND_SHORT = 2'd2;

  // Status of the alpha divider toward the sequencer
  typedef struct packed {
    logic               busy;
    logic [ALPHA_W-1:0] fast;
    logic [ALPHA_W-1:0] slow;
  } alpha_stat_t;

endpackage

FILE: hw/rtl/rfs_mul.sv
// Shared 17 x 24 bit multiplier with a registered product.
// Depends on rfs_pkg for operand widths.
module rfs_mul (
  input  logic                        clk,
  input  logic [rfs_pkg::MUL_A_W-1:0] a,
  input  logic [rfs_pkg::MUL_B_W-1:0] b,
  output logic [rfs_pkg::MUL_P_W-1:0] p
);

  // Register the product; the sequencer consumes it in the cycle after issue
  always_ff @(posedge clk) begin
    p <= {{rfs_pkg::MUL_B_W{1'b0}}, a} * {{rfs_pkg::MUL_A_W{1'b0}}, b};
  end

endmodule

FILE: hw/rtl/rfs_alpha.sv
// Restoring divider that derives both EMA alphas from the smoothing period.
// One quotient bit per cycle, fast alpha first, then slow; depends on rfs_pkg.
module rfs_alpha (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rfs_pkg::PERIOD_W-1:0] period,
  output rfs_pkg::alpha_stat_t         stat
);

  logic [rfs_pkg::PERIOD_W-1:0]  per_q;
  logic [rfs_pkg::PERIOD_W-1:0]  per_eff;
  logic                          phase;
  logic [rfs_pkg::DIV_CNT_W-1:0] cnt;
  logic [rfs_pkg::DIV_DIV_W-1:0] rem;
  logic [rfs_pkg::DIV_DIV_W-1:0] div;
  logic [rfs_pkg::DIV_DVD_W-1:0] dvd;
  logic [rfs_pkg::DIV_DIV_W-1:0] n_fast;
  logic [rfs_pkg::DIV_DIV_W-1:0] n_slow_q;
  logic [rfs_pkg::DIV_DIV_W:0]   rem_sh;
  logic                          ge;
  logic [rfs_pkg::DIV_DIV_W:0]   rem_sub;
  logic [rfs_pkg::DIV_DVD_W-1:0] quo;

  // Period zero acts as one
  assign per_eff  = (period == '0) ? rfs_pkg::PERIOD_W'(1) : period;
  assign n_fast   = {1'b0, per_eff} + rfs_pkg::DIV_DIV_W'(1);
  assign n_slow_q = {per_q, 1'b0};

  // One restoring step
  assign rem_sh  = {rem, dvd[rfs_pkg::DIV_DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, div};
  assign rem_sub = rem_sh - {1'b0, div};
  assign quo     = {dvd[rfs_pkg::DIV_DVD_W-2:0], ge};

  // Sequence the two divisions; a new period write restarts from the fast alpha
  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.fast <= rfs_pkg::ALPHA_FAST_RST;
      stat.slow <= rfs_pkg::ALPHA_SLOW_RST;
      phase     <= 1'b0;
      cnt       <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      phase     <= 1'b0;
      cnt       <= '0;
    end else if (stat.busy) begin
      if (cnt == rfs_pkg::DIV_LAST) begin
        cnt <= '0;
        if (!phase) begin
          stat.fast <= quo[rfs_pkg::ALPHA_W-1:0];
          phase     <= 1'b1;
        end else begin
          stat.slow <= quo[rfs_pkg::ALPHA_W-1:0];
          stat.busy <= 1'b0;
        end
      end else begin
        cnt <= cnt + rfs_pkg::DIV_CNT_W'(1);
      end
    end
  end

  // Datapath: load operands at start and between phases, else shift
  always_ff @(posedge clk) begin
    if (start) begin
      per_q <= per_eff;
      div   <= n_fast;
      rem   <= '0;
      dvd   <= rfs_pkg::ALPHA_TWO + rfs_pkg::DIV_DVD_W'(n_fast >> 1);
    end else if (stat.busy) begin
      if (cnt == rfs_pkg::DIV_LAST && !phase) begin
        div <= n_slow_q;
        rem <= '0;
        dvd <= rfs_pkg::ALPHA_TWO + rfs_pkg::DIV_DVD_W'(n_slow_q >> 1);
      end else begin
        rem <= ge ? rem_sub[rfs_pkg::DIV_DIV_W-1:0] : rem_sh[rfs_pkg::DIV_DIV_W-1:0];
        dvd <= quo;
      end
    end
  end

endmodule

FILE: hw/rtl/range_filter_swing_signal.sv
// Range filter swing signal: top level with sequencer, state and output register.
// Depends on rfs_pkg, rfs_mul (shared multiplier) and rfs_alpha (alpha divider).
//
// Each request carries one unsigned price sample; each yields one result with a
// long and a short swing flag. A request that starts a series (series_start, or
// the first after reset) reseeds all state and goes straight to the output state.
// Others go through a sequencer that walks two EMA updates and the range product
// through one shared 17 x 24 bit multiplier, each 48-bit operand in two partial
// products, then the filter band compare and the condition update; no request is
// taken until the sequencer is idle again. A write to smoothing_period recomputes
// both alphas in a bit-serial divider, and no request is taken while it runs. A
// finished result waits in the output register while the next request proceeds.
module range_filter_swing_signal (
  input  logic        clk,
  input  logic        rst,
  // Input requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] price
  input  logic        s_tuser,   // [0] series_start
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] long_signal, [1] short_signal, [7:2] zero
  // Configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DIFF = 5'd1;
  localparam logic [4:0] ST_D1   = 5'd2;
  localparam logic [4:0] ST_ML1  = 5'd3;
  localparam logic [4:0] ST_MH1  = 5'd4;
  localparam logic [4:0] ST_MA1  = 5'd5;
  localparam logic [4:0] ST_U1   = 5'd6;
  localparam logic [4:0] ST_D2   = 5'd7;
  localparam logic [4:0] ST_ML2  = 5'd8;
  localparam logic [4:0] ST_MH2  = 5'd9;
  localparam logic [4:0] ST_MA2  = 5'd10;
  localparam logic [4:0] ST_U2   = 5'd11;
  localparam logic [4:0] ST_ML3  = 5'd12;
  localparam logic [4:0] ST_MH3  = 5'd13;
  localparam logic [4:0] ST_MA3  = 5'd14;
  localparam logic [4:0] ST_RNG  = 5'd15;
  localparam logic [4:0] ST_BND  = 5'd16;
  localparam logic [4:0] ST_SEL  = 5'd17;
  localparam logic [4:0] ST_COND = 5'd18;
  localparam logic [4:0] ST_OUT  = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;

  logic [rfs_pkg::MULT_W-1:0]   mult;
  logic [rfs_pkg::MULT_W-1:0]   mult_eff;
  rfs_pkg::alpha_stat_t         alpha_st;

  logic [rfs_pkg::PRICE_W-1:0] price;
  logic [rfs_pkg::PRICE_W-1:0] prev_price;
  logic [rfs_pkg::PRICE_W-1:0] filter;
  logic [rfs_pkg::PRICE_W-1:0] diff;
  logic [rfs_pkg::AVG_W-1:0]   chg_avg;
  logic [rfs_pkg::AVG_W-1:0]   smo_avg;
  logic [rfs_pkg::AVG_W-1:0]   delta;
  logic                        dpos;
  logic [rfs_pkg::ACC_W-1:0]   acc;
  logic [rfs_pkg::RANGE_W-1:0] rng;
  logic [rfs_pkg::RANGE_W:0]   up_bound;
  logic [rfs_pkg::RANGE_W:0]   dn_bound;
  logic [1:0]                  trend;
  logic [1:0]                  last_cond;
  logic                        series_open;
  logic                        long_sig;
  logic                        short_sig;

  logic [rfs_pkg::MUL_A_W-1:0] mul_a;
  logic [rfs_pkg::MUL_B_W-1:0] mul_b;
  logic [rfs_pkg::MUL_P_W-1:0] mul_p;

  logic                        accept;
  logic                        out_free;
  logic [rfs_pkg::AVG_W-1:0]   ema_x;
  logic [rfs_pkg::AVG_W-1:0]   ema_avg;
  logic [rfs_pkg::AVG_W-1:0]   ema_inc;
  logic [rfs_pkg::AVG_W-1:0]   ema_new;
  logic [rfs_pkg::RANGE_W+16:0] rng_sum;
  logic [rfs_pkg::RANGE_W:0]   price_x;
  logic [rfs_pkg::RANGE_W:0]   filter_x;
  logic                        go_up;
  logic                        go_dn;
  logic                        moved;
  logic                        long_cond;
  logic                        short_cond;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE) && !alpha_st.busy;
  assign out_free = !m_tvalid || m_tready;
  assign mult_eff = (mult == '0) ? rfs_pkg::MULT_W'(1) : mult;

  // Configuration registers; a period write restarts the alpha divider
  always_ff @(posedge clk) begin
    if (rst) begin
      mult <= rfs_pkg::MULT_RST;
    end else if (cfg_we && cfg_index == rfs_pkg::CFG_MULT) begin
      mult <= cfg_data[rfs_pkg::MULT_W-1:0];
    end
  end

  rfs_alpha u_alpha (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_we && cfg_index == rfs_pkg::CFG_PERIOD),
    .period (cfg_data),
    .stat   (alpha_st)
  );

  // Steer the shared multiplier: low half, then high half of the wide operand
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_ML1: begin
        mul_a = alpha_st.fast;
        mul_b = delta[23:0];
      end
      ST_MH1: begin
        mul_a = alpha_st.fast;
        mul_b = delta[47:24];
      end
      ST_ML2: begin
        mul_a = alpha_st.slow;
        mul_b = delta[23:0];
      end
      ST_MH2: begin
        mul_a = alpha_st.slow;
        mul_b = delta[47:24];
      end
      ST_ML3: begin
        mul_a = rfs_pkg::MUL_A_W'(mult_eff);
        mul_b = smo_avg[23:0];
      end
      ST_MH3: begin
        mul_a = rfs_pkg::MUL_A_W'(mult_eff);
        mul_b = smo_avg[47:24];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  rfs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // EMA operands: first stage averages the scaled change, second the first average
  assign ema_x   = (state == ST_D1) ? {diff, 16'b0} : chg_avg;
  assign ema_avg = (state == ST_D1 || state == ST_U1) ? chg_avg : smo_avg;
  assign ema_inc = acc[rfs_pkg::AVG_W+rfs_pkg::AVG_FRAC-1:rfs_pkg::AVG_FRAC];
  assign ema_new = dpos ? ema_avg + ema_inc : ema_avg - ema_inc;

  // Range rounding and band compare operands
  assign rng_sum  = acc[rfs_pkg::RANGE_W+15:0] + (rfs_pkg::RANGE_W+17)'(32768);
  assign price_x  = (rfs_pkg::RANGE_W+1)'(price);
  assign filter_x = (rfs_pkg::RANGE_W+1)'(filter);
  assign go_up    = price_x > up_bound;
  assign go_dn    = dn_bound < filter_x;

  // Conditions against the updated filter
  assign moved      = price != prev_price;
  assign long_cond  = (price > filter) && (trend == rfs_pkg::DIR_UP) && moved;
  assign short_cond = !long_cond && (price < filter) && (trend == rfs_pkg::DIR_DOWN) && moved;

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (s_tuser || !series_open) ? ST_OUT : ST_DIFF;
        end
      end
      ST_DIFF: state_next = ST_D1;
      ST_D1:   state_next = ST_ML1;
      ST_ML1:  state_next = ST_MH1;
      ST_MH1:  state_next = ST_MA1;
      ST_MA1:  state_next = ST_U1;
      ST_U1:   state_next = ST_D2;
      ST_D2:   state_next = ST_ML2;
      ST_ML2:  state_next = ST_MH2;
      ST_MH2:  state_next = ST_MA2;
      ST_MA2:  state_next = ST_U2;
      ST_U2:   state_next = ST_ML3;
      ST_ML3:  state_next = ST_MH3;
      ST_MH3:  state_next = ST_MA3;
      ST_MA3:  state_next = ST_RNG;
      ST_RNG:  state_next = ST_BND;
      ST_BND:  state_next = ST_SEL;
      ST_SEL:  state_next = ST_COND;
      ST_COND: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state: series flag, trend and remembered condition
  always_ff @(posedge clk) begin
    if (rst) begin
      series_open <= 1'b0;
      trend       <= rfs_pkg::DIR_NONE;
      last_cond   <= rfs_pkg::COND_NONE;
    end else if (state == ST_IDLE && accept && (s_tuser || !series_open)) begin
      series_open <= 1'b1;
      trend       <= rfs_pkg::DIR_NONE;
      last_cond   <= rfs_pkg::COND_NONE;
    end else if (state == ST_SEL) begin
      if (go_up) begin
        trend <= rfs_pkg::DIR_UP;
      end else if (go_dn) begin
        trend <= rfs_pkg::DIR_DOWN;
      end
    end else if (state == ST_COND) begin
      if (long_cond) begin
        last_cond <= rfs_pkg::COND_LONG;
      end else if (short_cond) begin
        last_cond <= rfs_pkg::COND_SHORT;
      end
    end
  end

  // Datapath registers, advanced by the sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          price <= s_tdata;
          if (s_tuser || !series_open) begin
            prev_price <= s_tdata;
            filter     <= s_tdata;
            chg_avg    <= '0;
            smo_avg    <= '0;
            long_sig   <= 1'b0;
            short_sig  <= 1'b0;
          end
        end
      end
      ST_DIFF: begin
        diff <= (price >= prev_price) ? price - prev_price : prev_price - price;
      end
      ST_D1, ST_D2: begin
        dpos  <= ema_x >= ema_avg;
        delta <= (ema_x >= ema_avg) ? ema_x - ema_avg : ema_avg - ema_x;
      end
      ST_MH1, ST_MH2, ST_MH3: begin
        acc <= rfs_pkg::ACC_W'(mul_p);
      end
      ST_MA1, ST_MA2, ST_MA3: begin
        acc <= acc + {mul_p, 24'b0};
      end
      ST_U1: begin
        chg_avg <= ema_new;
      end
      ST_U2: begin
        smo_avg <= ema_new;
      end
      ST_RNG: begin
        rng <= rng_sum[rfs_pkg::RANGE_W+15:16];
      end
      ST_BND: begin
        up_bound <= filter_x + {1'b0, rng};
        dn_bound <= price_x + {1'b0, rng};
      end
      ST_SEL: begin
        if (go_up) begin
          filter <= price - rng[rfs_pkg::PRICE_W-1:0];
        end else if (go_dn) begin
          filter <= dn_bound[rfs_pkg::PRICE_W-1:0];
        end
      end
      ST_COND: begin
        long_sig   <= long_cond && (last_cond == rfs_pkg::COND_SHORT);
        short_sig  <= short_cond && (last_cond == rfs_pkg::COND_LONG);
        prev_price <= price;
      end
      default: begin
      end
    endcase
  end

  // Output register: load when the slot is free, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= {6'b0, short_sig, long_sig};
    end
  end

  // Both swing flags never rise together
  a_excl_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("long and short swing flags set together");

  // No request is taken while the alphas are being recomputed
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    alpha_st.busy |-> !s_tready)
    else $error("request accepted during alpha update");

  // An accepted request always leaves the idle state
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("sequencer stayed idle after a request");

  // A result is loaded only into a free output slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("pending result overwritten");

endmodule
